// ===== hdl/assert_macros.svh =====
// Assertion macros for the port checker file.
// Depends on nothing; included by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge, disabled during reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hdl/dhkv_pkg.sv =====
// Package of the double-hash key-value table: sizes, codes and types.
// Depends on nothing; used by the top level, the checkers and the testbench.
package dhkv_pkg;
   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int KEY_BYTES   = 8;
   localparam int VALUE_BYTES = 8;

   typedef enum logic [1:0] {FUNC_INSERT = 2'd0, FUNC_SEARCH = 2'd1,
                             FUNC_DELETE = 2'd2, FUNC_NOP = 2'd3} func_type;
   typedef enum logic [1:0] {STAT_OK = 2'd0, STAT_MISSING = 2'd1,
                             STAT_FULL = 2'd2, STAT_RSVD = 2'd3} status_type;
   typedef enum logic [1:0] {SLOT_EMPTY = 2'd0, SLOT_LIVE = 2'd1,
                             SLOT_TOMB = 2'd2, SLOT_RSVD = 2'd3} slot_type;
   typedef enum logic [1:0] {CSR_TABLE_SIZE = 2'd0, CSR_MULT_A = 2'd1,
                             CSR_MULT_B = 2'd2, CSR_NONE = 2'd3} csr_type;

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_HASH_MUL, S_HASH_RED, S_STEP, S_READ, S_WAIT, S_CHECK,
      S_ADV, S_WRITE, S_RESP
   } state_type;
endpackage

// ===== hdl/dhkv_ifc.sv =====
// Valid/ready channel interfaces of the double-hash key-value table.
// Depends on nothing.
interface dhkv_req_ifc;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [63:0] key;
   logic [3:0] key_len;
   logic [63:0] value;
   logic [3:0] value_len;
   modport source (output valid, func, key, key_len, value, value_len, input ready);
   modport sink   (input valid, func, key, key_len, value, value_len, output ready);
endinterface

interface dhkv_rsp_ifc;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [63:0] found_value;
   logic [3:0]  found_value_len;
   logic [10:0] entry_total;
   modport source (output valid, status, found_value, found_value_len, entry_total,
                   input ready);
   modport sink   (input valid, status, found_value, found_value_len, entry_total,
                   output ready);
endinterface

interface dhkv_csr_ifc;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/double_hash_key_value_table.sv =====
// Top level of the double-hash key-value table: sequencer, slot memory, shared unit.
// Depends on dhkv_pkg and the channel interfaces in dhkv_ifc.sv.
//
//   channel   direction  carries
//   req       in         func, key, key_len, value, value_len
//   rsp       out        status, found_value, found_value_len, entry_total
//   csr       in         index (0 size, 1 mult_a, 2 mult_b), 16-bit data
//
// After reset a clearing pass marks all 1024 slots empty, one slot a cycle,
// during which no request is taken; register writes still are.
// A request runs the two hashes over each key byte (each hash step is a
// multiply on the shared multiplier, then the shared restoring reducer),
// then the step, then probes through the registered slot memory read
// (read, wait, check and, but for the last probe, advance), plus a write
// and a response state; a no-op goes straight to its response state.
// The finished response moves into an output register and waits there until
// the transfer; the next request may be taken meanwhile, but it holds in its
// response cycle while that register is still full.
module double_hash_key_value_table (
   input logic clock,
   input logic reset,
   dhkv_req_ifc.sink req,
   dhkv_rsp_ifc.source rsp,
   dhkv_csr_ifc.sink csr
);
   import dhkv_pkg::*;

   // Configuration registers.
   logic [10:0] size_ff;
   logic [15:0] mult_a_ff, mult_b_ff;

   // Request registers.
   logic [1:0]  func_ff;
   logic [63:0] key_ff, val_ff;
   logic [3:0]  klen_ff, vlen_ff;
   logic [IDX_W:0] m_ff;   // effective bucket count, 1..TABLE_DEPTH

   // Sequencer registers.
   state_type state_ff, state_in;
   logic [3:0]  byte_ff;      // byte index into the key
   logic        which_ff;     // 0: primary hash, 1: step hash
   logic [IDX_W:0] ha_ff, hb_ff, idx_ff, step_ff;
   logic [31:0] prod_ff;      // shared multiplier output
   logic [IDX_W:0] probe_ff;  // probes done
   logic [IDX_W-1:0] clr_ff;
   logic        found_ff, empty_ff;
   logic [IDX_W:0] cnt_ff;

   // Result being built for the current request.
   logic [1:0]  rsp_status_ff;
   logic [63:0] rsp_val_ff;
   logic [3:0]  rsp_vlen_ff;

   // Output register that holds a finished response until its transfer.
   logic        rsp_valid_ff;
   logic [1:0]  out_status_ff;
   logic [63:0] out_val_ff;
   logic [3:0]  out_vlen_ff;
   logic [10:0] out_total_ff;

   // Slot memories.
   logic [1:0]  mem_stat [TABLE_DEPTH];
   logic [63:0] mem_key  [TABLE_DEPTH];
   logic [3:0]  mem_klen [TABLE_DEPTH];
   logic [63:0] mem_val  [TABLE_DEPTH];
   logic [3:0]  mem_vlen [TABLE_DEPTH];
   logic [1:0]  rd_stat_ff;
   logic [63:0] rd_key_ff, rd_val_ff;
   logic [3:0]  rd_klen_ff, rd_vlen_ff;

   logic [3:0]  klen_sat, vlen_sat;
   logic [63:0] kmask, vmask;
   logic [IDX_W:0] m_sel;
   logic [7:0]  cur_byte;
   logic [IDX_W:0] h_cur;
   logic [IDX_W+1:0] adv_sum;
   logic [IDX_W-1:0] addr;
   logic        last_byte, is_match;

   assign klen_sat = (req.key_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : req.key_len;
   assign vlen_sat = (req.value_len > 4'(VALUE_BYTES)) ? 4'(VALUE_BYTES) : req.value_len;
   assign kmask = (klen_sat >= 4'd8) ? '1 : ((64'd1 << {klen_sat, 3'b000}) - 64'd1);
   assign vmask = (vlen_sat >= 4'd8) ? '1 : ((64'd1 << {vlen_sat, 3'b000}) - 64'd1);
   assign m_sel = (size_ff == 11'd0) ? (IDX_W+1)'(1) :
                  (size_ff > 11'(TABLE_DEPTH)) ? (IDX_W+1)'(TABLE_DEPTH) :
                  (IDX_W+1)'(size_ff);

   // Byte byte_ff of the key, first byte first.
   assign cur_byte = 8'(key_ff >> {4'(klen_ff - 4'd1 - byte_ff), 3'b000});
   assign h_cur = which_ff ? hb_ff : ha_ff;
   assign last_byte = (byte_ff + 4'd1 >= klen_ff);
   assign adv_sum = {1'b0, idx_ff} + {1'b0, step_ff};
   assign addr = idx_ff[IDX_W-1:0];
   assign is_match = (rd_stat_ff == SLOT_LIVE) && (rd_klen_ff == klen_ff) &&
                     (rd_key_ff == key_ff);

   // Reduction of prod (< m*65536 + 256) needs many subtracts, so it runs
   // one bit position a cycle: a restoring shift-subtract over prod_ff.
   logic [4:0] red_bit_ff;
   logic [IDX_W+17:0] rem_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:    if (clr_ff == '1) state_in = S_IDLE;
         S_IDLE:     if (req.valid) begin
                        state_in = (req.func == FUNC_NOP) ? S_RESP :
                                   (klen_sat == 4'd0) ? S_STEP : S_HASH_MUL;
                     end
         S_HASH_MUL: state_in = S_HASH_RED;
         S_HASH_RED: if (red_bit_ff == 5'd0) begin
                        state_in = (which_ff && last_byte) ? S_STEP : S_HASH_MUL;
                     end
         S_STEP:     state_in = S_READ;
         S_READ:     state_in = S_WAIT;
         S_WAIT:     state_in = S_CHECK;
         S_CHECK:    state_in = (rd_stat_ff == SLOT_EMPTY || is_match ||
                                 probe_ff + 1'b1 >= m_ff) ? S_WRITE : S_ADV;
         S_ADV:      state_in = S_READ;
         S_WRITE:    state_in = S_RESP;
         S_RESP:     if (!rsp_valid_ff || rsp.ready) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.status = out_status_ff;
   assign rsp.found_value = out_val_ff;
   assign rsp.found_value_len = out_vlen_ff;
   assign rsp.entry_total = out_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         size_ff <= 11'd1021;
         mult_a_ff <= 16'd151;
         mult_b_ff <= 16'd163;
      end else begin
         state_ff <= state_in;
         if (csr.valid) begin
            unique case (csr_type'(csr.index))
               CSR_TABLE_SIZE: size_ff <= 11'(csr.data);
               CSR_MULT_A:     mult_a_ff <= csr.data;
               CSR_MULT_B:     mult_b_ff <= csr.data;
               default:        ;
            endcase
         end
         unique case (state_ff)
            S_CLEAR: clr_ff <= clr_ff + 1'b1;
            S_IDLE: if (req.valid) begin
               func_ff <= req.func;
               key_ff <= req.key & kmask;
               klen_ff <= klen_sat;
               val_ff <= req.value & vmask;
               vlen_ff <= vlen_sat;
               m_ff <= m_sel;
               ha_ff <= '0;
               hb_ff <= '0;
               byte_ff <= '0;
               which_ff <= 1'b0;
               found_ff <= 1'b0;
               empty_ff <= 1'b0;
               probe_ff <= '0;
               rsp_status_ff <= STAT_OK;
               rsp_val_ff <= '0;
               rsp_vlen_ff <= '0;
            end
            S_HASH_MUL: begin
               prod_ff <= 32'(h_cur) * 32'(which_ff ? mult_b_ff : mult_a_ff);
               red_bit_ff <= 5'd17;
               rem_ff <= '0;
            end
            S_HASH_RED: begin
               // One restoring divide step a cycle; remainder is the new hash.
               logic [IDX_W+18:0] t;
               if (red_bit_ff == 5'd17) begin
                  // Value below m*65536+256: reduce by m shifted 17 .. 0 places.
                  t = (IDX_W+19)'(32'(prod_ff) + 32'(cur_byte));
                  rem_ff <= (IDX_W+18)'((t >= ((IDX_W+19)'(m_ff) << 17)) ?
                                        t - ((IDX_W+19)'(m_ff) << 17) : t);
                  red_bit_ff <= 5'd16;
               end else begin
                  t = (IDX_W+19)'(rem_ff);
                  if (t >= ((IDX_W+19)'(m_ff) << red_bit_ff))
                     rem_ff <= (IDX_W+18)'(t - ((IDX_W+19)'(m_ff) << red_bit_ff));
                  red_bit_ff <= red_bit_ff - 5'd1;
                  if (red_bit_ff == 5'd0) begin
                     if (which_ff) begin
                        hb_ff <= (IDX_W+1)'((t >= (IDX_W+19)'(m_ff)) ? t - (IDX_W+19)'(m_ff) : t);
                        byte_ff <= byte_ff + 4'd1;
                     end else begin
                        ha_ff <= (IDX_W+1)'((t >= (IDX_W+19)'(m_ff)) ? t - (IDX_W+19)'(m_ff) : t);
                     end
                     which_ff <= ~which_ff;
                  end
               end
            end
            S_STEP: begin
               idx_ff <= ha_ff;
               step_ff <= ((hb_ff + 1'b1) >= m_ff) ? (hb_ff + 1'b1 - m_ff) : (hb_ff + 1'b1);
            end
            S_CHECK: begin
               found_ff <= is_match;
               empty_ff <= (rd_stat_ff == SLOT_EMPTY);
            end
            S_ADV: begin
               idx_ff <= (IDX_W+1)'((adv_sum >= {1'b0, m_ff}) ? adv_sum - {1'b0, m_ff} : adv_sum);
               probe_ff <= probe_ff + 1'b1;
            end
            S_WRITE: begin
               unique case (func_type'(func_ff))
                  FUNC_INSERT: if (found_ff) ;
                               else if (empty_ff) cnt_ff <= cnt_ff + 1'b1;
                               else rsp_status_ff <= STAT_FULL;
                  FUNC_SEARCH: if (found_ff) begin
                                  rsp_val_ff <= rd_val_ff;
                                  rsp_vlen_ff <= rd_vlen_ff;
                               end else rsp_status_ff <= STAT_MISSING;
                  FUNC_DELETE: if (found_ff) begin
                                  if (cnt_ff != '0) cnt_ff <= cnt_ff - 1'b1;
                               end else rsp_status_ff <= STAT_MISSING;
                  default: ;
               endcase
            end
            default: ;
         endcase
         // The response leaves its cycle only once the output register is free.
         if (state_ff == S_RESP && (!rsp_valid_ff || rsp.ready)) begin
            rsp_valid_ff <= 1'b1;
            out_status_ff <= rsp_status_ff;
            out_val_ff <= rsp_val_ff;
            out_vlen_ff <= rsp_vlen_ff;
            out_total_ff <= 11'(cnt_ff);
         end else if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Slot memory: one registered read port, one write port.
   logic we_stat, we_data, we_kv;
   logic [1:0] wstat;
   logic [IDX_W-1:0] waddr;
   always_comb begin
      we_stat = 1'b0; we_data = 1'b0; we_kv = 1'b0;
      wstat = SLOT_EMPTY;
      waddr = addr;
      if (state_ff == S_CLEAR) begin
         we_stat = 1'b1; waddr = clr_ff;
      end else if (state_ff == S_WRITE) begin
         if (func_ff == FUNC_INSERT && found_ff) we_data = 1'b1;
         else if (func_ff == FUNC_INSERT && empty_ff) begin
            we_data = 1'b1; we_kv = 1'b1; we_stat = 1'b1; wstat = SLOT_LIVE;
         end else if (func_ff == FUNC_DELETE && found_ff) begin
            we_stat = 1'b1; wstat = SLOT_TOMB;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we_stat) mem_stat[waddr] <= wstat;
      if (we_kv) begin
         mem_key[waddr]  <= key_ff;
         mem_klen[waddr] <= klen_ff;
      end
      if (we_data) begin
         mem_val[waddr]  <= val_ff;
         mem_vlen[waddr] <= vlen_ff;
      end
      if (state_ff == S_READ) begin
         rd_stat_ff <= mem_stat[addr];
         rd_key_ff  <= mem_key[addr];
         rd_klen_ff <= mem_klen[addr];
         rd_val_ff  <= mem_val[addr];
         rd_vlen_ff <= mem_vlen[addr];
      end
   end
endmodule

// ===== hdl/dhkv_checker.sv =====
// Port-level checker of the double-hash key-value table, with its bind.
// Depends on dhkv_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dhkv_port_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [1:0] rsp_status,
   input logic [3:0] rsp_vlen,
   input logic [10:0] rsp_total
);
   import dhkv_pkg::*;
   `CHK_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_status) && $stable(rsp_vlen) && $stable(rsp_total), "response changed while held")
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
   `CHK_IMPLY(a_status, clock, reset, rsp_valid, rsp_status != STAT_RSVD, "bad status")
   `CHK_IMPLY(a_total, clock, reset, rsp_valid, rsp_total <= 11'(TABLE_DEPTH), "count too big")
   `CHK_IMPLY(a_len, clock, reset, rsp_valid, rsp_vlen <= 4'(VALUE_BYTES), "length too big")
endmodule

bind double_hash_key_value_table dhkv_port_checker u_dhkv_port_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.status), .rsp_vlen(rsp.found_value_len),
   .rsp_total(rsp.entry_total)
);

// ===== verif/dhkv_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the double-hash key-value table: watches the request, result and
// register channels, predicts every result and compares. Depends on dhkv_pkg and dhkv_ifc.
module dhkv_checker (
   input  logic  clock,
   input  logic  reset,
   dhkv_req_ifc  req,
   dhkv_rsp_ifc  rsp,
   dhkv_csr_ifc  csr,
   output int    fail_count,
   output int    pending,
   output int    result_total,
   output int    found_total,
   output int    missing_total,
   output int    full_total
);
   import dhkv_pkg::*;

   typedef struct packed {
      status_type  status;
      logic [63:0] value;
      logic [3:0]  value_len;
      logic [10:0] total;
   } answer_type;

   answer_type  answer_queue[$];

   logic [10:0] size_reg;
   logic [15:0] base_a;
   logic [15:0] base_b;
   slot_type    bucket_state[TABLE_DEPTH];
   logic [63:0] bucket_key[TABLE_DEPTH];
   logic [3:0]  bucket_key_len[TABLE_DEPTH];
   logic [63:0] bucket_value[TABLE_DEPTH];
   logic [3:0]  bucket_value_len[TABLE_DEPTH];
   logic [10:0] live_count;

   function automatic logic [63:0] byte_mask(int unsigned n);
      if (n >= 8) return '1;
      return (64'd1 << (8 * n)) - 64'd1;
   endfunction

   function automatic int unsigned poly_hash(logic [63:0] k, int unsigned len,
                                             int unsigned base, int unsigned m);
      longint unsigned h;
      h = 0;
      for (int unsigned i = 0; i < len; i++)
         h = (h * base + ((k >> (8 * (len - 1 - i))) & 64'hFF)) % m;
      return 32'(h);
   endfunction

   // Walks the probe path of one request, applies it to the shadow table and
   // returns the answer the block must give.
   function automatic answer_type apply_request(logic [1:0] f, logic [63:0] k_in,
                                                logic [3:0] kl_in, logic [63:0] v_in,
                                                logic [3:0] vl_in);
      answer_type  a;
      int unsigned klen, vlen, m, idx, stride, hit_idx, free_idx;
      logic [63:0] k, v;
      bit          hit, free;
      a = '{STAT_OK, 64'd0, 4'd0, 11'd0};
      klen = (kl_in > KEY_BYTES) ? KEY_BYTES : kl_in;
      vlen = (vl_in > VALUE_BYTES) ? VALUE_BYTES : vl_in;
      k = k_in & byte_mask(klen);
      v = v_in & byte_mask(vlen);
      m = (size_reg == 0) ? 1 : ((size_reg > TABLE_DEPTH) ? TABLE_DEPTH : size_reg);
      hit = 0; free = 0; hit_idx = 0; free_idx = 0;
      if (func_type'(f) != FUNC_NOP) begin
         idx = poly_hash(k, klen, base_a, m);
         stride = (poly_hash(k, klen, base_b, m) + 1) % m;
         for (int unsigned t = 0; t < m; t++) begin
            if (bucket_state[idx] == SLOT_EMPTY) begin
               free = 1; free_idx = idx;
               break;
            end
            if (bucket_state[idx] == SLOT_LIVE && bucket_key_len[idx] == klen &&
                bucket_key[idx] == k) begin
               hit = 1; hit_idx = idx;
               break;
            end
            idx = (idx + stride) % m;
         end
         case (func_type'(f))
            FUNC_INSERT: begin
               if (hit) begin
                  bucket_value[hit_idx] = v;
                  bucket_value_len[hit_idx] = 4'(vlen);
               end else if (free) begin
                  bucket_state[free_idx] = SLOT_LIVE;
                  bucket_key[free_idx] = k;
                  bucket_key_len[free_idx] = 4'(klen);
                  bucket_value[free_idx] = v;
                  bucket_value_len[free_idx] = 4'(vlen);
                  live_count++;
               end else begin
                  a.status = STAT_FULL;
               end
            end
            FUNC_SEARCH: begin
               if (hit) begin
                  a.value = bucket_value[hit_idx];
                  a.value_len = bucket_value_len[hit_idx];
               end else begin
                  a.status = STAT_MISSING;
               end
            end
            default: begin
               if (hit) begin
                  bucket_state[hit_idx] = SLOT_TOMB;
                  if (live_count > 0) live_count--;
               end else begin
                  a.status = STAT_MISSING;
               end
            end
         endcase
      end
      a.total = live_count;
      return a;
   endfunction

   task automatic report_fail(string msg);
      fail_count++;
      if (fail_count <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   initial begin
      fail_count = 0; pending = 0; result_total = 0;
      found_total = 0; missing_total = 0; full_total = 0;
   end

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         size_reg = 11'd1021;
         base_a = 16'd151;
         base_b = 16'd163;
         live_count = 0;
         for (int i = 0; i < TABLE_DEPTH; i++) bucket_state[i] = SLOT_EMPTY;
         answer_queue.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr_type'(csr.index))
               CSR_TABLE_SIZE: size_reg = csr.data[10:0];
               CSR_MULT_A:     base_a = csr.data;
               CSR_MULT_B:     base_b = csr.data;
               default: ;
            endcase
         end
         // Results are checked before the request of the same edge is predicted.
         if (rsp.valid && rsp.ready) begin
            result_total++;
            if (answer_queue.size() == 0) begin
               report_fail("result transfer with no request outstanding");
            end else begin
               want = answer_queue.pop_front();
               if (rsp.status !== want.status || rsp.found_value !== want.value ||
                   rsp.found_value_len !== want.value_len ||
                   rsp.entry_total !== want.total)
                  report_fail($sformatf(
                     "expected st=%0d val=%h len=%0d total=%0d, got st=%0d val=%h len=%0d total=%0d",
                     want.status, want.value, want.value_len, want.total, rsp.status,
                     rsp.found_value, rsp.found_value_len, rsp.entry_total));
               case (want.status)
                  STAT_FULL:    full_total++;
                  STAT_MISSING: missing_total++;
                  default: if (want.value_len != 0) found_total++;
               endcase
            end
         end
         if (req.valid && req.ready)
            answer_queue.push_back(apply_request(req.func, req.key, req.key_len,
                                                 req.value, req.value_len));
      end
      pending = answer_queue.size();
   end
endmodule

// ===== verif/double_hash_key_value_table_tb.sv =====
`timescale 1ns / 1ps
// Top of the double-hash key-value table testbench: clock, reset, stimulus and verdict.
// Depends on dhkv_pkg, dhkv_ifc, the block and dhkv_checker.
module double_hash_key_value_table_tb;
   import dhkv_pkg::*;

   logic clock;
   logic reset;

   dhkv_req_ifc req_if ();
   dhkv_rsp_ifc rsp_if ();
   dhkv_csr_ifc csr_if ();

   int fail_count, pending, result_total, found_total, missing_total, full_total;

   // When calm is set neither side idles; a hold-off request makes the
   // receiver refuse results for a long stretch.
   bit calm;
   bit holdoff_request;
   int holdoff_left;

   // Key pool of the current phase, so that searches and deletes mostly hit.
   logic [63:0] pool_key[24];
   logic [3:0]  pool_len[24];

   double_hash_key_value_table u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   dhkv_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req_if),
      .rsp           (rsp_if),
      .csr           (csr_if),
      .fail_count    (fail_count),
      .pending       (pending),
      .result_total  (result_total),
      .found_total   (found_total),
      .missing_total (missing_total),
      .full_total    (full_total)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // The overall limit covers the clearing pass after reset and the worst case
   // of full probe runs with stalled results, several times over.
   initial begin
      #200ms;
      $display("Timeout: %0d requests still outstanding.", pending);
      $display("RESULT: ERROR");
      $finish;
   end

   // Result receiver: random back-pressure, calm stretches and one long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (holdoff_request || holdoff_left > 0) begin
         if (holdoff_request) begin
            holdoff_request = 0;
            holdoff_left = 400;
         end else begin
            holdoff_left--;
         end
         rsp_if.ready <= 1'b0;
      end else if (calm) begin
         rsp_if.ready <= 1'b1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= 29);
      end
   end

   // Offers one request and holds it until the transfer happens.
   task automatic send_request(func_type f, logic [63:0] k, logic [3:0] kl,
                               logic [63:0] v, logic [3:0] vl);
      while (!calm && $urandom_range(99) < 29) @(negedge clock);
      req_if.valid = 1'b1;
      req_if.func = f;
      req_if.key = k;
      req_if.key_len = kl;
      req_if.value = v;
      req_if.value_len = vl;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   task automatic write_register(csr_type index, logic [15:0] data);
      csr_if.valid = 1'b1;
      csr_if.index = index;
      csr_if.data = data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // Waits until every result is back, so registers may change safely.
   task automatic drain;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic new_pool;
      foreach (pool_key[i]) begin
         pool_key[i] = {$urandom, $urandom};
         pool_len[i] = 4'($urandom_range(1, 8));
      end
   endtask

   function automatic logic [63:0] random_value();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [3:0] random_value_len();
      return ($urandom_range(9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
   endfunction

   // Mostly well-formed traffic on the pool keys, with random bits above the
   // key length (which the block must ignore) and some pure noise.
   task automatic random_traffic(int count);
      int          pick, roll;
      logic [63:0] mask, k;
      func_type    f;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 10) begin
            send_request(func_type'($urandom_range(0, 3)), random_value(),
                         4'($urandom_range(0, 15)), random_value(), 4'($urandom_range(0, 15)));
         end else begin
            pick = $urandom_range(23);
            mask = (pool_len[pick] >= 8) ? '1 : (64'd1 << (8 * pool_len[pick])) - 1;
            k = (pool_key[pick] & mask) | (random_value() & ~mask);
            roll = $urandom_range(99);
            f = (roll < 40) ? FUNC_INSERT : (roll < 75) ? FUNC_SEARCH :
                (roll < 96) ? FUNC_DELETE : FUNC_NOP;
            send_request(f, k, pool_len[pick], random_value(), random_value_len());
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      calm = 0;
      holdoff_request = 0;
      holdoff_left = 0;
      req_if.valid = 1'b0;
      req_if.func = FUNC_NOP;
      req_if.key = '0;
      req_if.key_len = '0;
      req_if.value = '0;
      req_if.value_len = '0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_NONE;
      csr_if.data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part on the reset settings: field extremes, replace in place,
      // hits and misses, tombstones on the probe path, empty and oversized keys.
      send_request(FUNC_INSERT, 64'h0, 4'd1, 64'h0, 4'd0);
      send_request(FUNC_INSERT, '1, 4'd8, '1, 4'd8);
      send_request(FUNC_SEARCH, '1, 4'd8, '0, 4'd0);
      send_request(FUNC_SEARCH, 64'hFFFF_FFFF_FFFF_FF00, 4'd1, '0, 4'd0);
      send_request(FUNC_INSERT, '1, 4'd15, 64'h1234_5678_9ABC_DEF0, 4'd15);
      send_request(FUNC_SEARCH, '1, 4'd8, '0, 4'd0);
      send_request(FUNC_INSERT, 64'hA5, 4'd0, 64'h55AA, 4'd2);
      send_request(FUNC_SEARCH, 64'h0, 4'd0, '0, 4'd0);
      send_request(FUNC_SEARCH, 64'h0, 4'd1, '0, 4'd0);
      send_request(FUNC_INSERT, 64'h0102_0304_0506_0708, 4'd8, 64'hDEAD_BEEF, 4'd4);
      send_request(FUNC_INSERT, 64'h0102_0304_0506_0708, 4'd7, 64'hCAFE, 4'd2);
      send_request(FUNC_SEARCH, 64'h0102_0304_0506_0708, 4'd7, '0, 4'd0);
      send_request(FUNC_DELETE, 64'h0102_0304_0506_0708, 4'd8, '0, 4'd0);
      send_request(FUNC_DELETE, 64'h0102_0304_0506_0708, 4'd8, '0, 4'd0);
      send_request(FUNC_SEARCH, 64'h0102_0304_0506_0708, 4'd8, '0, 4'd0);
      send_request(FUNC_NOP, '1, 4'd8, '1, 4'd8);
      send_request(FUNC_DELETE, 64'h7777, 4'd2, '0, 4'd0);
      drain;

      // A tiny table with small bases: fills up, so full answers and
      // probe paths through tombstones are frequent.
      write_register(CSR_TABLE_SIZE, 16'd7);
      write_register(CSR_MULT_A, 16'd2);
      write_register(CSR_MULT_B, 16'd2);
      send_request(FUNC_INSERT, 64'h11, 4'd1, 64'h1, 4'd1);
      send_request(FUNC_INSERT, 64'h22, 4'd1, 64'h2, 4'd1);
      send_request(FUNC_INSERT, 64'h33, 4'd1, 64'h3, 4'd1);
      send_request(FUNC_INSERT, 64'h44, 4'd1, 64'h4, 4'd1);
      send_request(FUNC_INSERT, 64'h55, 4'd1, 64'h5, 4'd1);
      send_request(FUNC_INSERT, 64'h66, 4'd1, 64'h6, 4'd1);
      send_request(FUNC_INSERT, 64'h77, 4'd1, 64'h7, 4'd1);
      send_request(FUNC_INSERT, 64'h88, 4'd1, 64'h8, 4'd1);
      new_pool;
      random_traffic(110);
      drain;

      // Size zero behaves as a single bucket.
      write_register(CSR_TABLE_SIZE, 16'd0);
      random_traffic(40);
      drain;

      // Largest table and largest bases; the step is often even here, so some
      // probe runs cover only part of the table. The receiver holds off for a
      // long stretch at the start so the block backs up into its input.
      write_register(CSR_TABLE_SIZE, 16'd1024);
      write_register(CSR_MULT_A, 16'hFFFF);
      write_register(CSR_MULT_B, 16'hFFFF);
      new_pool;
      holdoff_request = 1;
      random_traffic(150);
      drain;

      // An all-ones size saturates to the table depth; the unused register
      // index must change nothing.
      write_register(CSR_TABLE_SIZE, 16'hFFFF);
      write_register(CSR_NONE, 16'h0005);
      random_traffic(100);
      drain;

      // Back to a small prime with no idling on either side.
      calm = 1;
      write_register(CSR_TABLE_SIZE, 16'd13);
      write_register(CSR_MULT_A, 16'd151);
      write_register(CSR_MULT_B, 16'd163);
      new_pool;
      random_traffic(150);
      drain;
      calm = 0;

      // Degenerate bases below the usual range.
      write_register(CSR_TABLE_SIZE, 16'd1021);
      write_register(CSR_MULT_A, 16'd1);
      write_register(CSR_MULT_B, 16'd0);
      new_pool;
      random_traffic(120);
      drain;

      write_register(CSR_TABLE_SIZE, 16'd64);
      write_register(CSR_MULT_A, 16'd31);
      write_register(CSR_MULT_B, 16'd37);
      random_traffic(155);

      drain;
      repeat (50) @(posedge clock);
      $display("Covered %0d results: %0d values found, %0d keys missing, %0d table full.",
               result_total, found_total, missing_total, full_total);
      $display("Table sizes 0 to 2047, bases 0 to 65535, one long result hold-off.");
      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d failures, %0d results never arrived.", fail_count, pending);
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
